>>> rtl/core/dpfm_pkg.sv
// ---------------------------------------------------------------------------
// dpfm_pkg
// Shared types and constants of the demand paging FIFO MMU.
// ---------------------------------------------------------------------------
package dpfm_pkg;

    localparam int PageBytesDef = 8;
    localparam int FramesDef    = 8;
    localparam int PagesDef     = 32;
    localparam int SwapSlotsDef = 32;

    localparam logic [7:0] FILL_BYTE = 8'h30;

    localparam logic [5:0] TEXT_RESET = 6'd2;
    localparam logic [5:0] DATA_RESET = 6'd2;
    localparam logic [5:0] HEAP_RESET = 6'd4;

    localparam logic [1:0] REG_TEXT = 2'd0;
    localparam logic [1:0] REG_DATA = 2'd1;
    localparam logic [1:0] REG_HEAP = 2'd2;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_STORE   = 2'd1;
    localparam logic [1:0] KIND_PRELOAD = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LIMIT    = 2'd1;
    localparam logic [1:0] ST_TEXT     = 2'd2;
    localparam logic [1:0] ST_SWAPFULL = 2'd3;

    // source of a page being brought into a frame
    typedef enum logic [1:0] {
        SRC_IMAGE = 2'd0,
        SRC_SWAP  = 2'd1,
        SRC_FILL  = 2'd2
    } t_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_EVICT_RD,
        S_EVICT_WR,
        S_LOAD_RD,
        S_LOAD_WR,
        S_COMMIT,
        S_ACCESS_RD,
        S_ACCESS_WR,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;      // capture input transaction
        logic decode;     // register lookup results
        logic scan_clr;   // restart swap slot scan
        logic scan_step;  // examine next swap slot
        logic ev_rd;      // read frame byte for eviction
        logic ev_wr;      // write swap byte
        logic ev_done;    // finish eviction bookkeeping
        logic ld_rd;      // read source byte
        logic ld_wr;      // write frame byte
        logic commit;     // finish page-in bookkeeping
        logic acc_rd;     // read accessed byte
        logic acc_wr;     // store byte, capture result
        logic cnt_clr;    // reset byte counter
        logic cnt_inc;    // advance byte counter
        logic set_status; // load result with fixed status
        logic [1:0] status;
        logic out_load;   // present the result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] kind;
        logic       beyond;
        logic       text_store;
        logic       resident;
        logic       wrapped;
        logic       victim_dirty;
        logic       scan_found;
        logic       scan_end;
        logic       cnt_last;
    } t_sts;

endpackage

>>> rtl/core/dpfm_ctrl.sv
// ---------------------------------------------------------------------------
// dpfm_ctrl
// Sequencer of the paging MMU: decode, evict, page in, access.
// ---------------------------------------------------------------------------
module dpfm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic            i_out_busy,
    input  dpfm_pkg::t_sts  i_sts,
    output dpfm_pkg::t_cmd  o_cmd
);

    dpfm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dpfm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            dpfm_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = dpfm_pkg::S_DECODE;
                end
            end
            dpfm_pkg::S_DECODE: begin
                o_cmd.decode  = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                n_state       = dpfm_pkg::S_DONE;
                if (i_sts.kind == dpfm_pkg::KIND_PRELOAD) begin
                    o_cmd.acc_wr = 1'b1;
                end else if (i_sts.kind == dpfm_pkg::KIND_LOAD ||
                             i_sts.kind == dpfm_pkg::KIND_STORE) begin
                    if (i_sts.beyond) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = dpfm_pkg::ST_LIMIT;
                    end else if (i_sts.text_store) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = dpfm_pkg::ST_TEXT;
                    end else if (i_sts.resident) begin
                        n_state = dpfm_pkg::S_ACCESS_RD;
                    end else if (i_sts.wrapped && i_sts.victim_dirty) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = dpfm_pkg::S_SCAN;
                    end else begin
                        n_state = dpfm_pkg::S_LOAD_RD;
                    end
                end else begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = dpfm_pkg::ST_OK;
                end
            end
            dpfm_pkg::S_SCAN: begin
                if (i_sts.scan_found) begin
                    n_state = dpfm_pkg::S_EVICT_RD;
                end else if (i_sts.scan_end) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = dpfm_pkg::ST_SWAPFULL;
                    n_state          = dpfm_pkg::S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            dpfm_pkg::S_EVICT_RD: begin
                o_cmd.ev_rd = 1'b1;
                n_state     = dpfm_pkg::S_EVICT_WR;
            end
            dpfm_pkg::S_EVICT_WR: begin
                o_cmd.ev_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.ev_done = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = dpfm_pkg::S_LOAD_RD;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = dpfm_pkg::S_EVICT_RD;
                end
            end
            dpfm_pkg::S_LOAD_RD: begin
                o_cmd.ld_rd = 1'b1;
                n_state     = dpfm_pkg::S_LOAD_WR;
            end
            dpfm_pkg::S_LOAD_WR: begin
                o_cmd.ld_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = dpfm_pkg::S_COMMIT;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = dpfm_pkg::S_LOAD_RD;
                end
            end
            dpfm_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = dpfm_pkg::S_ACCESS_RD;
            end
            dpfm_pkg::S_ACCESS_RD: begin
                o_cmd.acc_rd = 1'b1;
                n_state      = dpfm_pkg::S_ACCESS_WR;
            end
            dpfm_pkg::S_ACCESS_WR: begin
                o_cmd.acc_wr = 1'b1;
                n_state      = dpfm_pkg::S_DONE;
            end
            dpfm_pkg::S_DONE: begin
                // hold until the output register is free
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = dpfm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpfm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/dpfm_datapath.sv
// ---------------------------------------------------------------------------
// dpfm_datapath
// Page tables, frame/swap/image memories and result register.
// ---------------------------------------------------------------------------
module dpfm_datapath #(
    parameter int PAGE_BYTES = dpfm_pkg::PageBytesDef,
    parameter int FRAMES     = dpfm_pkg::FramesDef,
    parameter int PAGES      = dpfm_pkg::PagesDef,
    parameter int SWAP_SLOTS = dpfm_pkg::SwapSlotsDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [5:0]     i_cfg_data,
    input  logic [1:0]     i_kind,
    input  logic [8:0]     i_address,
    input  logic [7:0]     i_write_data,
    input  dpfm_pkg::t_cmd i_cmd,
    output dpfm_pkg::t_sts o_sts,
    output logic           o_out_busy,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_read_data,
    output logic [1:0]     o_status
);

    localparam int OW  = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PW  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int SW  = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
    localparam int SCW = $clog2(SWAP_SLOTS + 1);
    localparam int LW  = (FW > SW) ? FW : SW;
    localparam int FD  = FRAMES * PAGE_BYTES;
    localparam int SD  = SWAP_SLOTS * PAGE_BYTES;
    localparam int ID  = PAGES * PAGE_BYTES;

    // configuration
    logic [5:0] r_text, r_data, r_heap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text <= dpfm_pkg::TEXT_RESET;
            r_data <= dpfm_pkg::DATA_RESET;
            r_heap <= dpfm_pkg::HEAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpfm_pkg::REG_TEXT: r_text <= i_cfg_data;
                dpfm_pkg::REG_DATA: r_data <= i_cfg_data;
                dpfm_pkg::REG_HEAP: r_heap <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // latched transaction
    logic [1:0]    r_kind;
    logic [5:0]    r_pg6;
    logic [OW-1:0] r_off;
    logic [7:0]    r_wdata;
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_pg6   <= i_address[8:3];
            r_off   <= OW'(32'(i_address[2:0]) % PAGE_BYTES);
            r_wdata <= i_write_data;
        end
    end
    wire [PW-1:0] pg = r_pg6[PW-1:0];
    wire in_range = 32'(r_pg6) < PAGES;

    // page tables
    logic [PAGES-1:0]      r_pvalid, r_pdirty;
    logic [LW-1:0]         r_ploc [PAGES];
    logic [PW-1:0]         r_owner [FRAMES];
    logic [FW-1:0]         r_vptr;
    logic                  r_wrapped;
    logic [SWAP_SLOTS-1:0] r_slot_used;
    logic [SWAP_SLOTS-1:0] r_slot_fill; // slot reads as fill bytes
    logic [FRAMES-1:0]     r_frame_fill;

    // fault context
    logic [PW-1:0]  r_old;
    logic [SCW-1:0] r_scan;
    logic [OW-1:0]  r_cnt;
    dpfm_pkg::t_src r_src;
    logic [SW-1:0]  r_src_slot;
    logic [7:0]     r_byte;
    logic           r_byte_fill;

    wire [PW-1:0] old_pg = r_owner[r_vptr];
    wire [SW-1:0] scan_idx = r_scan[SW-1:0];
    wire [6:0] limit = 7'(r_text) + 7'(r_data) + 7'(r_heap);

    always_comb begin
        o_sts              = '0;
        o_sts.kind         = r_kind;
        o_sts.beyond       = (7'(r_pg6) >= limit) || !in_range;
        o_sts.text_store   = (r_kind == dpfm_pkg::KIND_STORE) && (r_pg6 < r_text);
        o_sts.resident     = r_pvalid[pg];
        o_sts.wrapped      = r_wrapped;
        o_sts.victim_dirty = r_pdirty[old_pg];
        o_sts.scan_end     = (32'(r_scan) >= SWAP_SLOTS);
        o_sts.scan_found   = !o_sts.scan_end && !r_slot_used[scan_idx];
        o_sts.cnt_last     = (32'(r_cnt) == PAGE_BYTES - 1);
    end

    // memories
    logic [7:0] r_frame [FD];
    logic [7:0] r_swap  [SD];
    logic [7:0] r_image [ID];
    logic [7:0] r_frame_q, r_swap_q, r_image_q;

    wire [$clog2(FD)-1:0] fr_base = $clog2(FD)'(32'(r_vptr) * PAGE_BYTES);
    wire [FW-1:0] loc_f = r_ploc[pg][FW-1:0];
    wire [$clog2(FD)-1:0] acc_addr =
        $clog2(FD)'(32'(loc_f) * PAGE_BYTES + 32'(r_off));
    wire [SW-1:0] ev_slot = scan_idx;
    wire [$clog2(SD)-1:0] ev_addr =
        $clog2(SD)'(32'(ev_slot) * PAGE_BYTES + 32'(r_cnt));
    wire [$clog2(SD)-1:0] src_saddr =
        $clog2(SD)'(32'(r_src_slot) * PAGE_BYTES + 32'(r_cnt));
    wire [$clog2(ID)-1:0] img_addr =
        $clog2(ID)'(32'(pg) * PAGE_BYTES + 32'(r_cnt));
    wire [$clog2(ID)-1:0] pre_addr =
        $clog2(ID)'(32'(pg) * PAGE_BYTES + 32'(r_off));
    wire [$clog2(FD)-1:0] fr_cnt_addr = fr_base + $clog2(FD)'(r_cnt);

    // frame memory: read for evict/access, write for page-in/store
    always_ff @(posedge i_clk) begin
        if (i_cmd.ev_rd) begin
            r_frame_q <= r_frame[fr_cnt_addr];
        end else if (i_cmd.acc_rd) begin
            r_frame_q <= r_frame[acc_addr];
        end
        if (i_cmd.ld_wr) begin
            r_frame[fr_cnt_addr] <= (r_src == dpfm_pkg::SRC_FILL || r_byte_fill) ?
                                    dpfm_pkg::FILL_BYTE : r_byte;
        end else if (i_cmd.acc_wr && r_kind == dpfm_pkg::KIND_STORE) begin
            r_frame[acc_addr] <= r_wdata;
        end
    end

    // swap memory: slots freed are marked fill instead of rewritten
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_rd) begin
            r_swap_q <= r_swap[src_saddr];
        end
        if (i_cmd.ev_wr) begin
            r_swap[ev_addr] <= r_frame_fill[r_vptr] ? dpfm_pkg::FILL_BYTE : r_frame_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_rd) begin
            r_image_q <= r_image[img_addr];
        end
        if (i_cmd.acc_wr && r_kind == dpfm_pkg::KIND_PRELOAD && in_range) begin
            r_image[pre_addr] <= r_wdata;
        end
    end

    // byte mux for page-in, on the registered read data
    always_comb begin
        case (r_src)
            dpfm_pkg::SRC_SWAP: r_byte = r_swap_q;
            default:            r_byte = r_image_q;
        endcase
        r_byte_fill = (r_src == dpfm_pkg::SRC_SWAP) && r_slot_fill[r_src_slot];
    end

    // control registers and tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid     <= '0;
            r_pdirty     <= '0;
            r_vptr       <= '0;
            r_wrapped    <= 1'b0;
            r_slot_used  <= '0;
            r_slot_fill  <= '1;
            r_frame_fill <= '1;
            r_scan       <= '0;
            r_cnt        <= '0;
            r_src        <= dpfm_pkg::SRC_FILL;
            r_src_slot   <= '0;
            r_old        <= '0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_step) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.decode) begin
                r_old <= old_pg;
                r_src_slot <= r_ploc[pg][SW-1:0];
                if (r_pg6 < r_text) begin
                    r_src <= dpfm_pkg::SRC_IMAGE;
                end else if (r_pdirty[pg]) begin
                    r_src <= dpfm_pkg::SRC_SWAP;
                end else if (7'(r_pg6) < 7'(r_text) + 7'(r_data)) begin
                    r_src <= dpfm_pkg::SRC_IMAGE;
                end else begin
                    r_src <= dpfm_pkg::SRC_FILL;
                end
                // clean victim drop: frees nothing, only invalidates
                if (r_kind[1] == 1'b0 && !o_sts.beyond && !o_sts.text_store &&
                    !r_pvalid[pg] && r_wrapped && !r_pdirty[old_pg]) begin
                    r_pvalid[old_pg] <= 1'b0;
                    r_ploc[old_pg]   <= '0;
                end
            end
            if (i_cmd.ev_done) begin
                r_slot_used[ev_slot] <= 1'b1;
                r_slot_fill[ev_slot] <= 1'b0;
                r_ploc[r_old]        <= LW'(ev_slot);
                r_pvalid[r_old]      <= 1'b0;
            end
            if (i_cmd.commit) begin
                if (r_src == dpfm_pkg::SRC_SWAP) begin
                    r_slot_used[r_src_slot] <= 1'b0;
                    r_slot_fill[r_src_slot] <= 1'b1;
                end
                r_frame_fill[r_vptr] <= 1'b0;
                r_owner[r_vptr] <= pg;
                r_pvalid[pg]    <= 1'b1;
                r_ploc[pg]      <= LW'(r_vptr);
                if (32'(r_vptr) == FRAMES - 1) begin
                    r_vptr    <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_vptr <= r_vptr + 1'b1;
                end
            end
            if (i_cmd.acc_wr && r_kind == dpfm_pkg::KIND_STORE) begin
                r_pdirty[pg] <= 1'b1;
            end
        end
    end

    // result register
    logic       r_valid;
    logic [7:0] r_res_data, r_rd;
    logic [1:0] r_res_st, r_st;
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_wr && r_kind != dpfm_pkg::KIND_PRELOAD) begin
            r_rd <= r_frame_fill[loc_f] ? dpfm_pkg::FILL_BYTE : r_frame_q;
        end else if (i_cmd.decode) begin
            r_rd <= '0;
        end
        if (i_cmd.set_status) begin
            r_st <= i_cmd.status;
        end else if (i_cmd.acc_wr && r_kind == dpfm_pkg::KIND_PRELOAD) begin
            r_st <= in_range ? dpfm_pkg::ST_OK : dpfm_pkg::ST_LIMIT;
        end else if (i_cmd.decode) begin
            r_st <= dpfm_pkg::ST_OK;
        end
        if (i_cmd.out_load) begin
            r_res_data <= r_rd;
            r_res_st   <= r_st;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_busy  = r_valid && i_stall;
    assign o_valid     = r_valid;
    assign o_read_data = r_res_data;
    assign o_status    = r_res_st;

endmodule

>>> rtl/core/demand_paging_fifo_mmu.sv
// ---------------------------------------------------------------------------
// demand_paging_fifo_mmu
// Demand-paged byte memory with FIFO frame replacement and swap.
// ---------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry kind, address and write_data; a
// transaction is taken when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall carry read_data and status, one result
// per input transaction, held in an output register while stalled.
// Configuration: i_cfg_we writes i_cfg_index (text, data, heap/stack pages).
// One transaction is in flight at a time. A hit runs decode, access read
// and access write before the result is loaded; a miss adds the page-in,
// a read and a write state per byte and then a commit, and a dirty
// eviction adds the swap slot scan for the first free slot plus a copy out
// to that slot. A full swap ends the scan with status ST_SWAPFULL. Frame
// and swap memory are read and written in separate states for each byte.
// Reset clears the valid and dirty bits, the FIFO pointer and the swap slot map;
// frame and swap contents read as fill bytes until written, no clear pass.
// While the receiver stalls, the finished result waits in the output
// register and the next transaction can run up to its own result.
// ---------------------------------------------------------------------------
module demand_paging_fifo_mmu #(
    parameter int PAGE_BYTES = dpfm_pkg::PageBytesDef,
    parameter int FRAMES     = dpfm_pkg::FramesDef,
    parameter int PAGES      = dpfm_pkg::PagesDef,
    parameter int SWAP_SLOTS = dpfm_pkg::SwapSlotsDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [5:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [8:0] i_address,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic [1:0] o_status
);

    dpfm_pkg::t_cmd cmd;
    dpfm_pkg::t_sts sts;
    logic           out_busy;

    dpfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_out_busy (out_busy),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dpfm_datapath #(
        .PAGE_BYTES (PAGE_BYTES),
        .FRAMES     (FRAMES),
        .PAGES      (PAGES),
        .SWAP_SLOTS (SWAP_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_busy   (out_busy),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_read_data  (o_read_data),
        .o_status     (o_status)
    );

endmodule
